// File: rtl/expanding_ring_band_shader_defines.svh
// Assertion macros for the expanding ring band shader.
// Each check is sampled on the rising edge of clk and is switched off during rst.
`ifndef EXPANDING_RING_BAND_SHADER_DEFINES_SVH
`define EXPANDING_RING_BAND_SHADER_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge.
`define ERBS_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ring band shader check failed");
// A condition that must hold whenever the trigger is true.
`define ERBS_CHECK_IMPL(lbl, trig, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
    else $error("ring band shader check failed");
`else
`define ERBS_CHECK(lbl, expr)
`define ERBS_CHECK_IMPL(lbl, trig, expr)
`endif

`endif

// File: rtl/erbs_pkg.sv
`default_nettype none

package erbs_pkg;

  // Default number of ring table slots.
  localparam int RING_SLOTS_DEF = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_BAND_HALF    = 2'd0;
  localparam logic [1:0] REG_CURRENT_TIME = 2'd1;
  localparam logic [1:0] REG_RING_COUNT   = 2'd2;

  // Item modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // 1.0 in Q1.16 (17 bits) and unsigned Q15.16 (31 bits).
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [30:0] BAND_HALF_RESET = 31'd65536;

  // One ring table entry.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        radius;
    logic [31:0]        t_start;
    logic [31:0]        t_end;
  } ring_entry_t;

endpackage

`default_nettype wire

// File: rtl/expanding_ring_band_shader.sv
// Load transaction: written to the ring table when accepted, no result.
// Query transaction: each ring is read and window-tested; a ring in its window then takes
// at most two 64-step restoring divisions and a 32-step square root.
// One transaction is processed at a time; the result register frees the input side early.
// Synchronous active-high reset clears control and the configuration registers only;
// the ring table is undefined until loaded.
`default_nettype none
`include "expanding_ring_band_shader_defines.svh"

module expanding_ring_band_shader
  import erbs_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               mode,
  input  wire logic [3:0]         entry_index,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [30:0]        final_radius,
  input  wire logic [31:0]        time_start,
  input  wire logic [31:0]        time_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    use_radar,
  output logic [16:0]             intensity
);

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RING_SLOTS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOOP     = 4'd1;
  localparam logic [3:0] S_READ     = 4'd2;
  localparam logic [3:0] S_DIV1SET  = 4'd3;
  localparam logic [3:0] S_DIV1     = 4'd4;
  localparam logic [3:0] S_SQX      = 4'd5;
  localparam logic [3:0] S_SQY      = 4'd6;
  localparam logic [3:0] S_SQZ      = 4'd7;
  localparam logic [3:0] S_SUM      = 4'd8;
  localparam logic [3:0] S_SQRTSET  = 4'd9;
  localparam logic [3:0] S_SQRT     = 4'd10;
  localparam logic [3:0] S_BAND     = 4'd11;
  localparam logic [3:0] S_DIV2     = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;

  // Configuration registers.
  logic [30:0] band_half;
  logic [31:0] current_time;
  logic [4:0]  ring_count;

  // Control and working registers.
  logic [3:0]         state;
  logic [CNT_W-1:0]   k;
  logic signed [31:0] hx, hy, hz;
  logic               found;
  logic [16:0]        best;
  logic [31:0]        ax, ay, az;
  logic [63:0]        prod;
  logic [65:0]        acc;
  logic [30:0]        radius_now;
  logic [63:0]        num;
  logic [31:0]        den;
  logic [31:0]        rem;
  logic [5:0]         step;
  logic [63:0]        sv;
  logic [63:0]        res;
  logic [63:0]        bitr;
  ring_entry_t        entry_q;
  ring_entry_t        ring_mem [RING_SLOTS];

  logic               in_fire;
  logic [8:0]         limit9;
  logic [SLOT_W-1:0]  k_idx;

  logic [31:0] mul_a, mul_b;
  logic [32:0] rem_s;
  logic        div_ge;
  logic [31:0] rem_next;
  logic [63:0] num_next;
  logic [63:0] sq_trial;
  logic        sq_ge;
  logic        in_window;
  logic signed [32:0] dx, dy, dz;
  logic [32:0] adx, ady, adz;
  logic        far_pt;
  logic [32:0] off;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign k_idx    = k[SLOT_W-1:0];
  assign limit9   = (9'(ring_count) > 9'(RING_SLOTS)) ? 9'(RING_SLOTS) : 9'(ring_count);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      band_half    <= BAND_HALF_RESET;
      current_time <= '0;
      ring_count   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BAND_HALF:    band_half    <= cfg_data[30:0];
        REG_CURRENT_TIME: current_time <= cfg_data;
        REG_RING_COUNT:   ring_count   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Ring table: written by load transactions, read at the loop index.
  always_ff @(posedge clk) begin
    if (in_fire && mode == MODE_LOAD && 9'(entry_index) < 9'(RING_SLOTS)) begin
      ring_mem[SLOT_W'(entry_index)] <= '{cx: pos_x, cy: pos_y, cz: pos_z,
                                          radius: final_radius,
                                          t_start: time_start, t_end: time_end};
    end
    entry_q <= ring_mem[k_idx];
  end

  // Shared multiplier, operands chosen by the sequencer.
  always_comb begin
    case (state)
      S_READ: begin
        mul_a = current_time - entry_q.t_start;
        mul_b = {1'b0, entry_q.radius};
      end
      S_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      S_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      default: begin
        mul_a = az;
        mul_b = az;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Restoring divider step, one quotient bit per cycle.
  assign rem_s    = {rem, num[63]};
  assign div_ge   = rem_s >= {1'b0, den};
  assign rem_next = div_ge ? 32'(rem_s - {1'b0, den}) : rem_s[31:0];
  assign num_next = {num[62:0], div_ge};

  // Square root step, one result bit per cycle.
  assign sq_trial = res + bitr;
  assign sq_ge    = sv >= sq_trial;

  // Window test and centre offsets for the entry just read.
  assign in_window = (entry_q.t_end > entry_q.t_start) &&
                     (current_time >= entry_q.t_start) &&
                     (current_time <= entry_q.t_end);
  assign dx  = {hx[31], hx} - {entry_q.cx[31], entry_q.cx};
  assign dy  = {hy[31], hy} - {entry_q.cy[31], entry_q.cy};
  assign dz  = {hz[31], hz} - {entry_q.cz[31], entry_q.cz};
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign adz = dz[32] ? 33'(-dz) : 33'(dz);
  assign far_pt = adx[32] || ady[32] || adz[32];

  // Distance from the band centre line.
  assign off = (res[31:0] >= {1'b0, radius_now}) ?
               33'({1'b0, res[31:0]} - {2'b0, radius_now}) :
               33'({2'b0, radius_now} - {1'b0, res[31:0]});

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      found     <= 1'b0;
      best      <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && mode == MODE_QUERY) begin
            hx    <= pos_x;
            hy    <= pos_y;
            hz    <= pos_z;
            k     <= '0;
            found <= 1'b0;
            best  <= '0;
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          state <= (9'(k) < limit9) ? S_READ : S_FIN;
        end
        S_READ: begin
          ax <= adx[31:0];
          ay <= ady[31:0];
          az <= adz[31:0];
          if (!in_window || far_pt) begin
            k     <= k + 1'b1;
            state <= S_LOOP;
          end else begin
            state <= S_DIV1SET;
          end
        end
        S_DIV1SET: begin
          num   <= prod;
          den   <= entry_q.t_end - entry_q.t_start;
          rem   <= '0;
          step  <= '0;
          state <= S_DIV1;
        end
        S_DIV1: begin
          num  <= num_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == 6'd63) begin
            radius_now <= num_next[30:0];
            state      <= S_SQX;
          end
        end
        S_SQX: begin
          state <= S_SQY;
        end
        S_SQY: begin
          acc   <= {2'b0, prod};
          state <= S_SQZ;
        end
        S_SQZ: begin
          acc   <= acc + {2'b0, prod};
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + {2'b0, prod};
          state <= S_SQRTSET;
        end
        S_SQRTSET: begin
          if (acc[65:64] != 2'b0) begin
            k     <= k + 1'b1;
            state <= S_LOOP;
          end else begin
            sv    <= acc[63:0];
            res   <= '0;
            bitr  <= 64'h4000_0000_0000_0000;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sv  <= sv - sq_trial;
            res <= (res >> 1) + bitr;
          end else begin
            res <= res >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr[0]) begin
            state <= S_BAND;
          end
        end
        S_BAND: begin
          if (off > {2'b0, band_half}) begin
            k     <= k + 1'b1;
            state <= S_LOOP;
          end else if (band_half == '0) begin
            best  <= ONE_Q16;
            found <= 1'b1;
            k     <= k + 1'b1;
            state <= S_LOOP;
          end else begin
            num   <= {15'b0, off, 16'b0};
            den   <= {1'b0, band_half};
            rem   <= '0;
            step  <= '0;
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          num  <= num_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == 6'd63) begin
            if (17'(ONE_Q16 - num_next[16:0]) > best) begin
              best <= 17'(ONE_Q16 - num_next[16:0]);
            end
            found <= 1'b1;
            k     <= k + 1'b1;
            state <= S_LOOP;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            use_radar <= found;
            intensity <= found ? best : ONE_Q16;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and arithmetic units.
  `ERBS_CHECK_IMPL(a_result_range, out_valid,
    (intensity <= ONE_Q16) && (use_radar || intensity == ONE_Q16))
  `ERBS_CHECK_IMPL(a_loop_bound, state == S_LOOP, 9'(k) <= limit9)
  `ERBS_CHECK_IMPL(a_div_rem, (state == S_DIV1) || (state == S_DIV2), rem < den)
  `ERBS_CHECK(a_sqrt_bit, (state != S_SQRT) || $onehot(bitr))

endmodule

`default_nettype wire
